// ===== design/ttmc_pkg.sv =====
// Shared types and constants for the truth table merge and combine block.
`default_nettype none

package ttmc_pkg;

    localparam int ID_WIDTH_DEF = 8;
    localparam int NUM_SLOTS    = 4;
    localparam int TT_BITS      = 16;
    localparam int POS_BITS     = 2;
    localparam int OP_BITS      = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_NOT  = 3'd0,
        OP_AND  = 3'd1,
        OP_OR   = 3'd2,
        OP_XOR  = 3'd3,
        OP_XNOR = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0][POS_BITS-1:0] pos;
        logic                               ovf;
    } merge_map_t;

endpackage

`default_nettype wire

// ===== design/truth_table_merge_combine.sv =====
// Top level of the truth table merge and combine block.
//
//  channel | dir | tdata (low bit up)                               | tuser
//  s_*     | in  | a_truth, a_slot0..3, b_truth, b_slot0..3, zeros | opcode
//  m_*     | out | out_truth, out_slot0..3, zeros                   | overflow
//
// One item per cycle while m_tready does not stall; each item passes the input register, then the result register.
// Input register feeds the merge and combine logic, which loads the result register.
// A stalled m_tready holds the result and the input register; s_tready drops only
// when both are full. rst_n clears the valid flags only.
`default_nettype none

module truth_table_merge_combine
    import ttmc_pkg::*;
#(
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // a_truth, a_slot0, a_slot1, a_slot2, a_slot3, b_truth, b_slot0..b_slot3, zero pad
    input  wire logic [((32 + 8*ID_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode
    input  wire logic [OP_BITS-1:0]     s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // out_truth, out_slot0, out_slot1, out_slot2, out_slot3, zero pad
    output logic [((16 + 4*ID_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    // overflow
    output logic [0:0]                  m_tuser
);

    localparam int B_TT_LSB   = TT_BITS + NUM_SLOTS * ID_WIDTH;
    localparam int B_SLOT_LSB = B_TT_LSB + TT_BITS;

    logic                               in_valid_reg;
    opcode_t                            opcode_reg;
    logic [TT_BITS-1:0]                 a_truth_reg;
    logic [TT_BITS-1:0]                 b_truth_reg;
    logic [NUM_SLOTS-1:0][ID_WIDTH-1:0] a_slots_reg;
    logic [NUM_SLOTS-1:0][ID_WIDTH-1:0] b_slots_reg;

    logic                               res_valid_reg;
    logic [TT_BITS-1:0]                 res_truth_reg;
    logic [NUM_SLOTS-1:0][ID_WIDTH-1:0] res_slots_reg;
    logic                               res_ovf_reg;

    logic [TT_BITS-1:0]                 res_truth_next;
    logic [NUM_SLOTS-1:0][ID_WIDTH-1:0] res_slots_next;
    logic                               res_ovf_next;
    logic [NUM_SLOTS-1:0][ID_WIDTH-1:0] merged_slots;
    merge_map_t                         map;

    logic                               advance;
    logic                               load_in;

    assign advance  = !res_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign load_in  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            opcode_reg  <= opcode_t'(s_tuser);
            a_truth_reg <= s_tdata[TT_BITS-1:0];
            b_truth_reg <= s_tdata[B_TT_LSB +: TT_BITS];
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                a_slots_reg[i] <= s_tdata[TT_BITS + i*ID_WIDTH +: ID_WIDTH];
                b_slots_reg[i] <= s_tdata[B_SLOT_LSB + i*ID_WIDTH +: ID_WIDTH];
            end
        end
        if (advance && in_valid_reg)
        begin
            res_truth_reg <= res_truth_next;
            res_slots_reg <= res_slots_next;
            res_ovf_reg   <= res_ovf_next;
        end
    end

    ttmc_merge #(
        .ID_WIDTH (ID_WIDTH)
    ) u_merge (
        .a_slots      (a_slots_reg),
        .b_slots      (b_slots_reg),
        .merged_slots (merged_slots),
        .map          (map)
    );

    ttmc_combine #(
        .ID_WIDTH (ID_WIDTH)
    ) u_combine (
        .opcode       (opcode_reg),
        .a_truth      (a_truth_reg),
        .b_truth      (b_truth_reg),
        .a_slots      (a_slots_reg),
        .merged_slots (merged_slots),
        .map          (map),
        .out_truth    (res_truth_next),
        .out_slots    (res_slots_next),
        .overflow     (res_ovf_next)
    );

    always_comb
    begin
        m_tdata              = '0;
        m_tdata[TT_BITS-1:0] = res_truth_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            m_tdata[TT_BITS + i*ID_WIDTH +: ID_WIDTH] = res_slots_reg[i];
        end
    end

    assign m_tvalid   = res_valid_reg;
    assign m_tuser[0] = res_ovf_reg;

endmodule

`default_nettype wire

// ===== design/ttmc_merge.sv =====
// Slot merge: places the B operand's signal ids into the merged slot list.
`default_nettype none

module ttmc_merge
    import ttmc_pkg::*;
#(
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  wire logic [NUM_SLOTS-1:0][ID_WIDTH-1:0] a_slots,
    input  wire logic [NUM_SLOTS-1:0][ID_WIDTH-1:0] b_slots,
    output logic      [NUM_SLOTS-1:0][ID_WIDTH-1:0] merged_slots,
    output merge_map_t                              map
);

    logic [NUM_SLOTS-1:0][ID_WIDTH-1:0] m;
    logic [NUM_SLOTS-1:0][POS_BITS-1:0] pos;
    logic [NUM_SLOTS-1:0]               mapped;
    logic [NUM_SLOTS-1:0]               used;
    logic                               live;
    logic                               ovf;
    logic                               found;
    logic [POS_BITS-1:0]                idx;

    always_comb
    begin
        m      = a_slots;
        pos    = '0;
        mapped = '0;
        used   = '0;
        live   = 1'b1;
        ovf    = 1'b0;
        found  = 1'b0;
        idx    = '0;
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            if (!live || (b_slots[j] == '0))
            begin
                live = 1'b0;
            end
            else
            begin
                found = 1'b0;
                idx   = '0;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!found && ((m[i] == '0) || (m[i] == b_slots[j])))
                    begin
                        found = 1'b1;
                        idx   = POS_BITS'(i);
                    end
                end
                if (found)
                begin
                    m[idx]    = b_slots[j];
                    pos[j]    = idx;
                    mapped[j] = 1'b1;
                    used[idx] = 1'b1;
                end
                else
                begin
                    ovf = 1'b1;
                end
            end
        end
        // give unplaced B positions the lowest unclaimed slots
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            if (!mapped[j])
            begin
                found = 1'b0;
                idx   = '0;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!found && !used[i])
                    begin
                        found = 1'b1;
                        idx   = POS_BITS'(i);
                    end
                end
                if (found)
                begin
                    pos[j]    = idx;
                    used[idx] = 1'b1;
                end
            end
        end
    end

    assign merged_slots = m;
    assign map.pos      = pos;
    assign map.ovf      = ovf;

endmodule

`default_nettype wire

// ===== design/ttmc_combine.sv =====
// Permute B's truth table onto the merged slots and apply the operation.
`default_nettype none

module ttmc_combine
    import ttmc_pkg::*;
#(
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  wire opcode_t                            opcode,
    input  wire logic [TT_BITS-1:0]                 a_truth,
    input  wire logic [TT_BITS-1:0]                 b_truth,
    input  wire logic [NUM_SLOTS-1:0][ID_WIDTH-1:0] a_slots,
    input  wire logic [NUM_SLOTS-1:0][ID_WIDTH-1:0] merged_slots,
    input  wire merge_map_t                         map,
    output logic      [TT_BITS-1:0]                 out_truth,
    output logic      [NUM_SLOTS-1:0][ID_WIDTH-1:0] out_slots,
    output logic                                    overflow
);

    logic [TT_BITS-1:0]   pb;
    logic [NUM_SLOTS-1:0] k;
    logic [NUM_SLOTS-1:0] m_idx;

    always_comb
    begin
        pb    = '0;
        k     = '0;
        m_idx = '0;
        for (int i = 0; i < TT_BITS; i++)
        begin
            m_idx = NUM_SLOTS'(i);
            for (int j = 0; j < NUM_SLOTS; j++)
            begin
                k[j] = m_idx[map.pos[j]];
            end
            pb[i] = b_truth[k];
        end
    end

    always_comb
    begin
        out_slots = merged_slots;
        overflow  = map.ovf;
        case (opcode)
            OP_AND:  out_truth = a_truth & pb;
            OP_OR:   out_truth = a_truth | pb;
            OP_XOR:  out_truth = a_truth ^ pb;
            OP_XNOR: out_truth = ~(a_truth ^ pb);
            OP_NOT:
            begin
                out_truth = ~a_truth;
                out_slots = a_slots;
                overflow  = 1'b0;
            end
            default:
            begin
                out_truth = a_truth;
                out_slots = a_slots;
                overflow  = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire
